/* design/rrt_pkg.sv */
// rrt_pkg: shared types, byte codes and widths for the reply tokenizer
// no dependencies; imported by the interfaces, the parser, the top level and the checker
`timescale 1ns / 1ps
`default_nettype none

package rrt_pkg;

    localparam int LengthBitsDefault = 31;
    localparam int CfgBits           = 31;
    localparam int LenOutBits        = 32;

    localparam logic [CfgBits-1:0] MaxBulkReset = 31'd536870912;

    localparam logic [7:0] ChDollar = 8'h24;
    localparam logic [7:0] ChStar   = 8'h2A;
    localparam logic [7:0] ChPlus   = 8'h2B;
    localparam logic [7:0] ChColon  = 8'h3A;
    localparam logic [7:0] ChMinus  = 8'h2D;
    localparam logic [7:0] ChCr     = 8'h0D;
    localparam logic [7:0] ChLf     = 8'h0A;
    localparam logic [7:0] ChZero   = 8'h30;
    localparam logic [7:0] ChOne    = 8'h31;
    localparam logic [7:0] ChNine   = 8'h39;

    typedef enum logic [3:0] {
        PH_TYPE      = 4'd0,
        PH_LEN_FIRST = 4'd1,
        PH_LEN_DIG   = 4'd2,
        PH_LEN_NEG   = 4'd3,
        PH_LEN_NEGCR = 4'd4,
        PH_LEN_LF    = 4'd5,
        PH_BULK      = 4'd6,
        PH_BULK_CR   = 4'd7,
        PH_BULK_LF   = 4'd8,
        PH_LINE      = 4'd9,
        PH_LINE_LF   = 4'd10
    } t_phase;

    typedef enum logic [1:0] {
        EV_HEADER = 2'd0,
        EV_DATA   = 2'd1,
        EV_END    = 2'd2,
        EV_ERROR  = 2'd3
    } t_event;

    typedef enum logic [2:0] {
        TY_BULK   = 3'd0,
        TY_ARRAY  = 3'd1,
        TY_STATUS = 3'd2,
        TY_ERRLN  = 3'd3,
        TY_INT    = 3'd4
    } t_item;

    typedef enum logic [2:0] {
        ERR_NONE  = 3'd0,
        ERR_TYPE  = 3'd1,
        ERR_DIGIT = 3'd2,
        ERR_LF    = 3'd3,
        ERR_LONG  = 3'd4
    } t_err;

    typedef struct packed {
        logic                  has_res;
        t_event                ev;
        t_item                 ty;
        logic [LenOutBits-1:0] len;
        logic [7:0]            data;
        t_err                  err;
    } t_result;

endpackage

`default_nettype wire

/* design/rrt_ifs.sv */
// rrt_ifs: valid/ready channel interfaces for received bytes, the limit register and results
// depends on rrt_pkg
`timescale 1ns / 1ps
`default_nettype none

interface rrt_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface rrt_cfg_if import rrt_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [CfgBits-1:0] max_bulk_length;

    modport source (output valid, output max_bulk_length, input ready);
    modport sink   (input valid, input max_bulk_length, output ready);
endinterface

interface rrt_res_if import rrt_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic [1:0]                   event_res;
    logic [2:0]                   item_type;
    logic signed [LenOutBits-1:0] item_length;
    logic [7:0]                   data_byte;
    logic [2:0]                   error_code;

    modport source (output valid, output event_res, output item_type, output item_length,
                    output data_byte, output error_code, input ready);
    modport sink   (input valid, input event_res, input item_type, input item_length,
                    input data_byte, input error_code, output ready);
endinterface

`default_nettype wire

/* design/rrt_parse.sv */
// rrt_parse: tokenizer state and single-byte step logic
// depends on rrt_pkg; the result is combinational and registered by the top level
`timescale 1ns / 1ps
`default_nettype none

module rrt_parse import rrt_pkg::*; #(
    parameter int LENGTH_BITS = LengthBitsDefault
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_step,
    input  wire logic [7:0]             i_byte,
    input  wire logic [LENGTH_BITS-1:0] i_limit,
    output t_result                     o_res
);

    localparam int AccWideBits = LENGTH_BITS + 4;

    t_phase                 r_phase, n_phase;
    t_item                  r_type,  n_type;
    logic [LENGTH_BITS-1:0] r_acc,   n_acc;
    logic                   r_neg,   n_neg;
    logic [LENGTH_BITS-1:0] r_rem,   n_rem;

    logic                   w_digit;
    logic [3:0]             w_digit_val;
    logic [AccWideBits-1:0] w_acc_x10;
    logic                   w_too_long;
    logic [LENGTH_BITS-1:0] w_rem_dec;
    logic                   w_fail;
    t_err                   w_err;
    t_item                  w_fail_ty;

    assign w_digit     = (i_byte >= ChZero) && (i_byte <= ChNine);
    assign w_digit_val = 4'(i_byte - ChZero);
    // acc*10 + digit as two shifts and adds
    assign w_acc_x10   = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1)
                       + AccWideBits'(w_digit_val);
    assign w_too_long  = w_acc_x10 > {4'b0, i_limit};
    assign w_rem_dec   = r_rem - LENGTH_BITS'(1);

    always_comb begin
        n_phase   = r_phase;
        n_type    = r_type;
        n_acc     = r_acc;
        n_neg     = r_neg;
        n_rem     = r_rem;
        w_fail    = 1'b0;
        w_err     = ERR_NONE;
        w_fail_ty = r_type;
        o_res     = '{has_res: 1'b0, ev: EV_HEADER, ty: r_type, len: '0, data: '0,
                      err: ERR_NONE};

        case (r_phase)
            PH_TYPE: begin
                n_acc = '0;
                n_neg = 1'b0;
                n_rem = '0;
                case (i_byte)
                    ChDollar: begin
                        n_type  = TY_BULK;
                        n_phase = PH_LEN_FIRST;
                    end
                    ChStar: begin
                        n_type  = TY_ARRAY;
                        n_phase = PH_LEN_FIRST;
                    end
                    ChPlus: begin
                        n_type  = TY_STATUS;
                        n_phase = PH_LINE;
                    end
                    ChMinus: begin
                        n_type  = TY_ERRLN;
                        n_phase = PH_LINE;
                    end
                    ChColon: begin
                        n_type  = TY_INT;
                        n_phase = PH_LINE;
                    end
                    default: begin
                        n_type    = TY_BULK;
                        w_fail    = 1'b1;
                        w_err     = ERR_TYPE;
                        w_fail_ty = TY_BULK;
                    end
                endcase
            end
            PH_LEN_FIRST, PH_LEN_DIG: begin
                if (r_phase == PH_LEN_FIRST && i_byte == ChMinus) begin
                    n_neg   = 1'b1;
                    n_phase = PH_LEN_NEG;
                end else if (r_phase == PH_LEN_DIG && i_byte == ChCr) begin
                    n_phase = PH_LEN_LF;
                end else if (!w_digit) begin
                    w_fail = 1'b1;
                    w_err  = ERR_DIGIT;
                end else if (w_too_long) begin
                    w_fail = 1'b1;
                    w_err  = ERR_LONG;
                end else begin
                    n_acc   = w_acc_x10[LENGTH_BITS-1:0];
                    n_phase = PH_LEN_DIG;
                end
            end
            PH_LEN_NEG: begin
                if (i_byte != ChOne) begin
                    w_fail = 1'b1;
                    w_err  = ERR_DIGIT;
                end else begin
                    n_phase = PH_LEN_NEGCR;
                end
            end
            PH_LEN_NEGCR: begin
                if (i_byte != ChCr) begin
                    w_fail = 1'b1;
                    w_err  = ERR_DIGIT;
                end else begin
                    n_phase = PH_LEN_LF;
                end
            end
            PH_LEN_LF: begin
                if (i_byte != ChLf) begin
                    w_fail = 1'b1;
                    w_err  = ERR_LF;
                end else begin
                    o_res.has_res = 1'b1;
                    o_res.ev      = EV_HEADER;
                    o_res.len     = r_neg ? '1
                                  : {{(LenOutBits-LENGTH_BITS){1'b0}}, r_acc};
                    // only a non-null bulk has a payload; arrays and nulls end here
                    if (r_type == TY_BULK && !r_neg) begin
                        n_rem   = r_acc;
                        n_phase = (r_acc != '0) ? PH_BULK : PH_BULK_CR;
                    end else begin
                        n_phase = PH_TYPE;
                    end
                end
            end
            PH_BULK: begin
                n_rem         = w_rem_dec;
                o_res.has_res = 1'b1;
                o_res.ev      = EV_DATA;
                o_res.data    = i_byte;
                if (w_rem_dec == '0) begin
                    n_phase = PH_BULK_CR;
                end
            end
            PH_BULK_CR: begin
                if (i_byte != ChCr) begin
                    w_fail = 1'b1;
                    w_err  = ERR_LF;
                end else begin
                    n_phase = PH_BULK_LF;
                end
            end
            PH_BULK_LF, PH_LINE_LF: begin
                if (i_byte != ChLf) begin
                    w_fail = 1'b1;
                    w_err  = ERR_LF;
                end else begin
                    o_res.has_res = 1'b1;
                    o_res.ev      = EV_END;
                    n_phase       = PH_TYPE;
                end
            end
            PH_LINE: begin
                if (i_byte == ChCr) begin
                    n_phase = PH_LINE_LF;
                end else begin
                    o_res.has_res = 1'b1;
                    o_res.ev      = EV_DATA;
                    o_res.data    = i_byte;
                end
            end
            default: begin
                w_fail = 1'b1;
                w_err  = ERR_TYPE;
            end
        endcase

        // any error drops the item and waits for a fresh type byte
        if (w_fail) begin
            n_phase = PH_TYPE;
            n_acc   = '0;
            n_neg   = 1'b0;
            n_rem   = '0;
            o_res   = '{has_res: 1'b1, ev: EV_ERROR, ty: w_fail_ty, len: '0, data: '0,
                        err: w_err};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_TYPE;
            r_type  <= TY_BULK;
            r_acc   <= '0;
            r_neg   <= 1'b0;
            r_rem   <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_type  <= n_type;
            r_acc   <= n_acc;
            r_neg   <= n_neg;
            r_rem   <= n_rem;
        end
    end

endmodule

`default_nettype wire

/* design/resp_reply_tokenizer.sv */
// path: input register, then the rrt_parse step, then the result register for any result
// throughput: one byte per cycle, set by the combinational step of rrt_parse between the
// input register and the result register; a stalled result holds both stages
// reset (synchronous, active low): tokenizer waits for a type byte, both stages empty,
// length limit back to its reset value
`timescale 1ns / 1ps
`default_nettype none

module resp_reply_tokenizer import rrt_pkg::*; #(
    parameter int LENGTH_BITS = LengthBitsDefault
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    rrt_byte_if.sink   i_rx,
    rrt_cfg_if.sink    i_cfg,
    rrt_res_if.source  o_res
);

    localparam logic [CfgBits-1:0] LimitCap =
        CfgBits'((64'd1 << LENGTH_BITS) - 64'd1);
    localparam logic [CfgBits-1:0] LimitResetFull =
        (MaxBulkReset > LimitCap) ? LimitCap : MaxBulkReset;
    localparam logic [LENGTH_BITS-1:0] LimitReset = LimitResetFull[LENGTH_BITS-1:0];

    logic                   r_in_valid;
    logic [7:0]             r_in_byte;
    logic                   r_out_valid;
    t_result                r_out;
    logic [LENGTH_BITS-1:0] r_limit;

    logic                   w_out_free;
    logic                   w_step;
    t_result                w_res;
    logic [CfgBits-1:0]     w_cfg_clip;

    assign w_out_free = !r_out_valid || o_res.ready;
    assign w_step     = r_in_valid && w_out_free;
    assign i_rx.ready = !r_in_valid || w_step;
    assign i_cfg.ready = 1'b1;

    assign w_cfg_clip = (i_cfg.max_bulk_length > LimitCap) ? LimitCap
                                                           : i_cfg.max_bulk_length;

    rrt_parse #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_byte  (r_in_byte),
        .i_limit (r_limit),
        .o_res   (w_res)
    );

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_rx.valid && i_rx.ready) begin
            r_in_valid <= 1'b1;
        end else if (w_step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_in_byte <= i_rx.rx_byte;
        end
    end

    // result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step && w_res.has_res) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step && w_res.has_res) begin
            r_out <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LimitReset;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_limit <= w_cfg_clip[LENGTH_BITS-1:0];
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.event_res   = r_out.ev;
    assign o_res.item_type   = r_out.ty;
    assign o_res.item_length = r_out.len;
    assign o_res.data_byte   = r_out.data;
    assign o_res.error_code  = r_out.err;

endmodule

`default_nettype wire

/* design/rrt_checker.sv */
// rrt_checker: port-level assertions on the result channel of the tokenizer
// depends on rrt_pkg; bound to resp_reply_tokenizer at the end of this file
`timescale 1ns / 1ps
`default_nettype none

module rrt_checker import rrt_pkg::*; (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         i_valid,
    input wire logic                         i_ready,
    input wire logic [1:0]                   i_event_res,
    input wire logic [2:0]                   i_item_type,
    input wire logic signed [LenOutBits-1:0] i_item_length,
    input wire logic [7:0]                   i_data_byte,
    input wire logic [2:0]                   i_error_code
);

    // a stalled transaction keeps its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_event_res) && $stable(i_item_type)
            && $stable(i_item_length) && $stable(i_data_byte) && $stable(i_error_code))
        else $error("result changed while stalled");

    a_err_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_event_res != EV_ERROR) |-> (i_error_code == ERR_NONE))
        else $error("error code on a non-error transaction");

    a_len_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_event_res != EV_HEADER) |-> (i_item_length == '0))
        else $error("length outside a header");

    a_bad_type: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_error_code == ERR_TYPE) |-> (i_item_type == TY_BULK)
            && (i_data_byte == '0))
        else $error("bad type error carries an item type or data");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_valid)
        else $error("result valid straight after reset");

endmodule

bind resp_reply_tokenizer rrt_checker u_rrt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (o_res.valid),
    .i_ready       (o_res.ready),
    .i_event_res   (o_res.event_res),
    .i_item_type   (o_res.item_type),
    .i_item_length (o_res.item_length),
    .i_data_byte   (o_res.data_byte),
    .i_error_code  (o_res.error_code)
);

`default_nettype wire
